>>> design/tsps_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tsps_pkg;

  // field and register widths
  localparam int unsigned IDX_W      = 16;
  localparam int unsigned N_W        = 16;
  localparam int unsigned TERM_CNT_W = 5;
  localparam int unsigned OUT_W      = 57;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 16;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLES = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_TERMS   = 1'b1;

  localparam logic [N_W-1:0]        SAMPLES_RST = 16'd256;
  localparam logic [TERM_CNT_W-1:0] TERMS_RST   = 5'd8;

  // 2*pi with 61 fraction bits
  localparam logic [63:0] TWO_PI_Q61 = 64'hC90F_DAA2_2168_C235;
  localparam int unsigned ANGLE_FRAC = 61;

  // shared multiplier: 64x64 product built from 32x32 limbs
  localparam int unsigned OP_W      = 64;
  localparam int unsigned LIMB_W    = 32;
  localparam int unsigned PROD_W    = 2 * OP_W;
  localparam int unsigned MUL_STEPS = 4;
  localparam int unsigned MCNT_W    = 3;

  // shared divider: restoring, several quotient bits per cycle
  localparam int unsigned DIV_W      = IDX_W + OP_W;
  localparam int unsigned DVSR_W     = 16;
  localparam int unsigned DIV_BITS   = 8;
  localparam int unsigned DIV_CYCLES = DIV_W / DIV_BITS;
  localparam int unsigned DCNT_W     = $clog2(DIV_CYCLES);

  localparam int unsigned SUM_W = 64;
  localparam logic signed [SUM_W-1:0] OUT_MAX = 64'sh00FF_FFFF_FFFF_FFFF;
  localparam logic signed [SUM_W-1:0] OUT_MIN = 64'shFF00_0000_0000_0000;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ANG_MUL,
    S_ANG_DIV,
    S_CLAMP,
    S_SQR_MUL,
    S_ACC,
    S_TERM_MUL,
    S_TERM_DIV,
    S_DONE
  } tsps_state_e;

  // (2k)(2k+1), the divisor that takes one series term to the next
  function automatic logic [DVSR_W-1:0] term_divisor(input logic [5:0] k);
    logic [13:0] k2;
    k2 = {7'd0, k, 1'b0};
    return DVSR_W'(k2 * (k2 + 14'd1));
  endfunction

endpackage

`default_nettype wire

>>> design/tsps_in_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface tsps_in_if;
  import tsps_pkg::*;

  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] sample_index;

  modport source (output valid, output sample_index, input ready);
  modport sink (input valid, input sample_index, output ready);
endinterface

`default_nettype wire

>>> design/tsps_out_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface tsps_out_if;
  import tsps_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] sine_value;
  logic                    saturated;

  modport source (output valid, output sine_value, output saturated, input ready);
  modport sink (input valid, input sine_value, input saturated, output ready);
endinterface

`default_nettype wire

>>> design/taylor_sine_partial_sum.sv
// Taylor partial sum of sin(2*pi*i/N), fixed point with FRAC_BITS fraction bits.
// Channels: in_i takes a request carrying sample_index; out_o returns sine_value
// and the saturated flag, one result per request, in order. Both use valid/ready.
// Configuration: cfg_we_i writes cfg_data_i into register cfg_idx_i
// (0: samples_per_period, 1: term_count); write only while the block is idle.
// Datapath: one 64x64 multiplier built from four 32x32 limb products and one
// restoring divider retiring 8 quotient bits a cycle are shared: the multiplier
// by the angle, square and term products, the divider by the angle and term
// divisions. Each summed term after the first costs one product, one division
// and one accumulate.
// Requests: one at a time; the block returns to idle before it takes the next.
// A finished result sits in the output register; the block takes the next
// request while it waits, and holds in its final step only if a second result
// is ready before the first is taken.
// Reset: samples_per_period = 256, term_count = 8, no result pending.
`timescale 1ns / 1ps
`default_nettype none

module taylor_sine_partial_sum #(
  parameter int MAX_TERMS = 16,
  parameter int FRAC_BITS = 40
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [tsps_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  wire logic [tsps_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  tsps_in_if.sink                                in_i,
  tsps_out_if.source                             out_o
);
  import tsps_pkg::*;

  localparam int unsigned KW          = $clog2(MAX_TERMS + 1);
  localparam int unsigned ANGLE_SHIFT = ANGLE_FRAC - FRAC_BITS;
  localparam logic [OP_W-1:0] ANGLE_MAX = 64'd8 << FRAC_BITS;

  tsps_state_e state_q, state_d;

  logic [N_W-1:0]        n_q;
  logic [TERM_CNT_W-1:0] tc_q;

  logic [OP_W-1:0]   a_q, b_q, pp_q, pp_d;
  logic [1:0]        pp_sh_q, pp_sh_d;
  logic [MCNT_W-1:0] mcnt_q;
  logic [PROD_W-1:0] acc_q, acc_sum;
  logic [LIMB_W-1:0] a_limb, b_limb;

  logic [DIV_W-1:0]  dvd_q, div_dvd_d;
  logic [DVSR_W-1:0] rem_q, div_rem_d, dvsr_q;
  logic [DVSR_W:0]   trial;
  logic [DCNT_W-1:0] dcnt_q;

  logic [OP_W-1:0]         mag_q, x2_q, x_w;
  logic [DIV_W-1:0]        ang_full;
  logic                    ang_big;
  logic signed [SUM_W-1:0] sum_q, sum_sat;
  logic                    sat_q, sat_w;
  logic [KW-1:0]           k_q, terms_q, terms_w;

  logic                    out_val_q;
  logic signed [OUT_W-1:0] out_sine_q;
  logic                    out_sat_q;

  logic mul_busy, mul_last, mul_start;
  logic div_busy, div_last, div_start;
  logic acc_last, out_load;

  // ---------------- shared multiplier ----------------
  always_comb begin
    a_limb  = mcnt_q[0] ? a_q[OP_W-1:LIMB_W] : a_q[LIMB_W-1:0];
    b_limb  = mcnt_q[1] ? b_q[OP_W-1:LIMB_W] : b_q[LIMB_W-1:0];
    pp_d    = OP_W'(a_limb) * OP_W'(b_limb);
    pp_sh_d = {1'b0, mcnt_q[0]} + {1'b0, mcnt_q[1]};
    acc_sum = acc_q + (PROD_W'(pp_q) << (LIMB_W * pp_sh_q));
  end

  assign mul_busy = (state_q == S_ANG_MUL) || (state_q == S_SQR_MUL) ||
                    (state_q == S_TERM_MUL);
  assign mul_last = mul_busy && (mcnt_q == MCNT_W'(MUL_STEPS));

  // ---------------- shared divider ----------------
  always_comb begin
    div_rem_d = rem_q;
    div_dvd_d = dvd_q;
    trial     = '0;
    for (int j = 0; j < DIV_BITS; j++) begin
      trial     = {div_rem_d, div_dvd_d[DIV_W-1]};
      div_dvd_d = {div_dvd_d[DIV_W-2:0], 1'b0};
      if (trial >= {1'b0, dvsr_q}) begin
        div_rem_d    = DVSR_W'(trial - {1'b0, dvsr_q});
        div_dvd_d[0] = 1'b1;
      end else begin
        div_rem_d = trial[DVSR_W-1:0];
      end
    end
  end

  assign div_busy = (state_q == S_ANG_DIV) || (state_q == S_TERM_DIV);
  assign div_last = div_busy && (dcnt_q == DCNT_W'(DIV_CYCLES - 1));

  // ---------------- angle clamp, term count, output saturation ----------------
  always_comb begin
    ang_full = dvd_q >> ANGLE_SHIFT;
    ang_big  = ang_full > DIV_W'(ANGLE_MAX);
    x_w      = ang_big ? ANGLE_MAX : ang_full[OP_W-1:0];

    if (32'(tc_q) > 32'(MAX_TERMS)) begin
      terms_w = KW'(MAX_TERMS);
    end else begin
      terms_w = KW'(tc_q);
    end

    sat_w   = sat_q;
    sum_sat = sum_q;
    if (sum_q > OUT_MAX) begin
      sum_sat = OUT_MAX;
      sat_w   = 1'b1;
    end else if (sum_q < OUT_MIN) begin
      sum_sat = OUT_MIN;
      sat_w   = 1'b1;
    end
  end

  // ---------------- sequencer ----------------
  assign acc_last  = (KW'(k_q + KW'(1)) == terms_q);
  assign out_load  = (state_q == S_DONE) && (!out_val_q || out_o.ready);
  assign mul_start = ((state_q == S_IDLE) && in_i.valid) || (state_q == S_CLAMP) ||
                     ((state_q == S_ACC) && !acc_last);
  assign div_start = mul_last && ((state_q == S_ANG_MUL) || (state_q == S_TERM_MUL));

  always_comb begin
    state_d    = state_q;
    in_i.ready = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_i.ready = 1'b1;
        if (in_i.valid) state_d = S_ANG_MUL;
      end
      S_ANG_MUL: begin
        if (mul_last) state_d = S_ANG_DIV;
      end
      S_ANG_DIV: begin
        if (div_last) state_d = S_CLAMP;
      end
      S_CLAMP: begin
        state_d = S_SQR_MUL;
      end
      S_SQR_MUL: begin
        if (mul_last) state_d = (terms_q == '0) ? S_DONE : S_ACC;
      end
      S_ACC: begin
        state_d = acc_last ? S_DONE : S_TERM_MUL;
      end
      S_TERM_MUL: begin
        if (mul_last) state_d = S_TERM_DIV;
      end
      S_TERM_DIV: begin
        if (div_last) state_d = S_ACC;
      end
      S_DONE: begin
        if (out_load) state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      n_q       <= SAMPLES_RST;
      tc_q      <= TERMS_RST;
      mcnt_q    <= '0;
      dcnt_q    <= '0;
      k_q       <= '0;
      out_val_q <= 1'b0;
    end else begin
      state_q <= state_d;

      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_SAMPLES: n_q  <= cfg_data_i[N_W-1:0];
          CFG_TERMS:   tc_q <= cfg_data_i[TERM_CNT_W-1:0];
          default: ;
        endcase
      end

      if (mul_start) begin
        mcnt_q <= '0;
      end else if (mul_busy) begin
        mcnt_q <= mcnt_q + MCNT_W'(1);
      end

      if (div_start) begin
        dcnt_q <= '0;
      end else if (div_busy) begin
        dcnt_q <= dcnt_q + DCNT_W'(1);
      end

      if (state_q == S_CLAMP) begin
        k_q <= '0;
      end else if (state_q == S_ACC) begin
        k_q <= KW'(k_q + KW'(1));
      end

      if (out_load) begin
        out_val_q <= 1'b1;
      end else if (out_o.ready) begin
        out_val_q <= 1'b0;
      end
    end
  end

  // ---------------- datapath ----------------
  always_ff @(posedge clk_i) begin
    if (mul_busy) begin
      pp_q    <= pp_d;
      pp_sh_q <= pp_sh_d;
      if (mcnt_q != '0) acc_q <= acc_sum;
    end

    case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          a_q     <= OP_W'(in_i.sample_index);
          b_q     <= TWO_PI_Q61;
          acc_q   <= '0;
          dvsr_q  <= (n_q == '0) ? DVSR_W'(1) : n_q;
          terms_q <= terms_w;
        end
      end
      S_ANG_MUL: begin
        if (mul_last) begin
          dvd_q <= acc_sum[DIV_W-1:0];
          rem_q <= '0;
        end
      end
      S_ANG_DIV: begin
        dvd_q <= div_dvd_d;
        rem_q <= div_rem_d;
      end
      S_CLAMP: begin
        sat_q <= ang_big;
        mag_q <= x_w;
        a_q   <= x_w;
        b_q   <= x_w;
        acc_q <= '0;
        sum_q <= '0;
      end
      S_SQR_MUL: begin
        if (mul_last) x2_q <= acc_sum[FRAC_BITS +: OP_W];
      end
      S_ACC: begin
        // odd terms are subtracted
        if (k_q[0]) begin
          sum_q <= sum_q - $signed(mag_q);
        end else begin
          sum_q <= sum_q + $signed(mag_q);
        end
        a_q   <= mag_q;
        b_q   <= x2_q;
        acc_q <= '0;
      end
      S_TERM_MUL: begin
        if (mul_last) begin
          dvd_q  <= DIV_W'(acc_sum[FRAC_BITS +: OP_W]);
          rem_q  <= '0;
          dvsr_q <= term_divisor(6'(k_q));
        end
      end
      S_TERM_DIV: begin
        dvd_q <= div_dvd_d;
        rem_q <= div_rem_d;
        if (div_last) mag_q <= div_dvd_d[OP_W-1:0];
      end
      S_DONE: begin
        if (out_load) begin
          out_sine_q <= sum_sat[OUT_W-1:0];
          out_sat_q  <= sat_w;
        end
      end
      default: ;
    endcase
  end

  assign out_o.valid      = out_val_q;
  assign out_o.sine_value = out_sine_q;
  assign out_o.saturated  = out_sat_q;

  // ---------------- assertions ----------------
  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> (state_q == S_ANG_MUL))
    else $error("accepted request did not start the angle product");

  a_term_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ACC) |-> (k_q < terms_q))
    else $error("term index ran past the term count");

  a_mag_positive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ACC) |-> !mag_q[OP_W-1])
    else $error("term magnitude overflowed");

  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_o.valid) |-> ($past(state_q) == S_DONE))
    else $error("result raised outside the final step");

endmodule

`default_nettype wire
